// ===== hdl/mfde_pkg.sv =====
// Shared types and constants for the monochrome frame buffer draw engine.
// Holds the opcode and command-kind codes and the queued command record.
// No dependencies.
package mfde_pkg;

	// Coordinates are carried one bit wider than their ports. This leaves room
	// for an exclusive edge that equals the screen size.
	localparam int XW = 9;
	localparam int YW = 7;

	typedef enum logic [2:0] {
		OP_SET_PIXEL = 3'd0,
		OP_FILL_SCREEN = 3'd1,
		OP_CLEAR_RECT = 3'd2,
		OP_FILL_RECT = 3'd3,
		OP_READ_BYTE = 3'd4,
		OP_FLUSH = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		K_NONE,
		K_FILL,
		K_FLUSH,
		K_RMW,
		K_READ
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic status;
		logic set;
		logic mark;
		logic [XW-1:0] x0;
		logic [XW-1:0] x1;
		logic [YW-1:0] y0;
		logic [YW-1:0] y1;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RMW,
		B_READ
	} back_state_t;

endpackage

// ===== hdl/mono_framebuffer_draw_engine_top.sv =====
// Top level of the monochrome 1-bit-per-pixel frame buffer draw engine.
// Joins mfde_front, mfde_queue and mfde_back. Uses mfde_pkg.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------------
//   in      | in_valid / in_stall | op, x_start, y_start, x_end, y_end, pixel_value
//   out     | out_valid/out_stall | status, read_data, dirty_flag
//
// Fill, flush and rejected commands finish in the back end's idle state. Read
// and pixel commands pass through a B_READ or B_RMW state after it. Rectangles
// step through B_RMW one row at a time, bounded by the row-wide store, with one
// masked row update per row.
// At reset every row is marked as not written, so the store reads as zeros at
// once and there is no clearing pass. A stall on the output holds the result
// register, and the queue keeps taking commands until it is full.
module mono_framebuffer_draw_engine_top #(
	parameter int ROW_BYTES = 16,
	parameter int ROWS = 36,
	parameter int QUEUE_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] op,
	input logic [7:0] x_start,
	input logic [5:0] y_start,
	input logic [7:0] x_end,
	input logic [5:0] y_end,
	input logic pixel_value,
	output logic out_valid,
	input logic out_stall,
	output logic status,
	output logic [7:0] read_data,
	output logic dirty_flag
);
	import mfde_pkg::*;

	// Classified commands pass from the front to the back through the queue.
	// The queue status goes back to the front for its stall.
	cmd_t push_cmd;
	cmd_t head;
	q_status_t q_status;
	logic q_push;
	logic q_pop;

	mfde_front #(
		.ROW_BYTES(ROW_BYTES),
		.ROWS(ROWS)
	) u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.pixel_value(pixel_value),
		.q_status(q_status),
		.push(q_push),
		.cmd(push_cmd)
	);

	mfde_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(push_cmd),
		.pop(q_pop),
		.head(head),
		.q_status(q_status)
	);

	// The back end owns the store, the dirty flag and the result register.
	mfde_back #(
		.ROW_BYTES(ROW_BYTES),
		.ROWS(ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_status(q_status),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.read_data(read_data),
		.dirty_flag(dirty_flag)
	);

	// The back end never pops an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("command popped from an empty queue");

	// The front end never pushes into a full queue.
	a_push_notfull: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("command pushed into a full queue");

	// A rejected command never returns store data.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (read_data == 8'h00))
		else $error("rejected command returned nonzero read data");

endmodule

// ===== hdl/mfde_front.sv =====
// Front end of the draw engine: takes commands and classifies them.
// Range checks turn each command into a queued record. Uses mfde_pkg.
module mfde_front #(
	parameter int ROW_BYTES = 16,
	parameter int ROWS = 36
) (
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] op,
	input logic [7:0] x_start,
	input logic [5:0] y_start,
	input logic [7:0] x_end,
	input logic [5:0] y_end,
	input logic pixel_value,
	input mfde_pkg::q_status_t q_status,
	output logic push,
	output mfde_pkg::cmd_t cmd
);
	import mfde_pkg::*;

	localparam logic [XW-1:0] SCREEN_W = XW'(ROW_BYTES * 8);
	localparam logic [YW-1:0] SCREEN_H = YW'(ROWS);

	logic [XW-1:0] xs;
	logic [XW-1:0] xe;
	logic [YW-1:0] ys;
	logic [YW-1:0] ye;
	logic pix_ok;
	logic rect_ok;

	assign in_stall = q_status.full;
	assign push = in_valid && !q_status.full;

	assign xs = {1'b0, x_start};
	assign xe = {1'b0, x_end};
	assign ys = {1'b0, y_start};
	assign ye = {1'b0, y_end};

	assign pix_ok = (xs < SCREEN_W) && (ys < SCREEN_H);
	assign rect_ok = (xs <= SCREEN_W) && (xe <= SCREEN_W) && (ys <= SCREEN_H)
		&& (ye <= SCREEN_H) && (xs < xe) && (ys < ye);

	always_comb begin
		cmd.kind = K_NONE;
		cmd.status = 1'b1;
		cmd.set = pixel_value;
		cmd.mark = 1'b0;
		cmd.x0 = xs;
		cmd.x1 = xe;
		cmd.y0 = ys;
		cmd.y1 = ye;
		unique case (op_t'(op))
			OP_SET_PIXEL: begin
				// A single pixel is a one-row, one-column rectangle.
				cmd.x1 = xs + XW'(1);
				cmd.y1 = ys + YW'(1);
				if (pix_ok) begin
					cmd.kind = K_RMW;
					cmd.status = 1'b0;
				end
			end
			OP_FILL_SCREEN: begin
				cmd.kind = K_FILL;
				cmd.status = 1'b0;
			end
			OP_CLEAR_RECT, OP_FILL_RECT: begin
				cmd.set = (op_t'(op) == OP_FILL_RECT);
				cmd.mark = 1'b1;
				if (rect_ok) begin
					cmd.kind = K_RMW;
					cmd.status = 1'b0;
				end
			end
			OP_READ_BYTE: begin
				if (pix_ok) begin
					cmd.kind = K_READ;
					cmd.status = 1'b0;
				end
			end
			OP_FLUSH: begin
				cmd.kind = K_FLUSH;
				cmd.status = 1'b0;
			end
			default: begin
				cmd.kind = K_NONE;
				cmd.status = 1'b1;
			end
		endcase
	end

endmodule

// ===== hdl/mfde_queue.sv =====
// Short command queue between the front and back of the draw engine.
// Stores classified command records in order. Uses mfde_pkg.
module mfde_queue #(
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mfde_pkg::cmd_t push_cmd,
	input logic pop,
	output mfde_pkg::cmd_t head,
	output mfde_pkg::q_status_t q_status
);
	import mfde_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t ent_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	assign head = ent_q[rd_ptr_q];
	assign q_status.full = (count_q == CW'(DEPTH));
	assign q_status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hdl/mfde_back.sv =====
// Back end of the draw engine: the row-wide frame store and its sequencer.
// Carries out queued commands and holds the result register. Uses mfde_pkg.
module mfde_back #(
	parameter int ROW_BYTES = 16,
	parameter int ROWS = 36
) (
	input logic clk,
	input logic arst_n,
	input mfde_pkg::cmd_t head,
	input mfde_pkg::q_status_t q_status,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic status,
	output logic [7:0] read_data,
	output logic dirty_flag
);
	import mfde_pkg::*;

	localparam int W = ROW_BYTES * 8;
	localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

	back_state_t state_q;
	back_state_t state_d;

	logic [W-1:0] mem_q [ROWS];
	logic [W-1:0] rd_data_q;
	logic rd_vld_q;
	logic [ROWS-1:0] row_vld_q;
	logic fill_val_q;
	logic dirty_q;

	cmd_t cur_q;
	logic [W-1:0] mask_q;
	logic [W-1:0] mask_d;
	logic [YW-1:0] nxt_row_q;
	logic [RAW-1:0] wr_row_q;

	logic res_vld_q;
	logic res_status_q;
	logic [7:0] res_data_q;
	logic res_dirty_q;

	logic res_free;
	logic last_row;
	logic [W-1:0] eff_row;
	logic [W-1:0] merged;
	logic [BW-1:0] byte_idx;
	logic [7:0] sel_byte;

	logic ld_cur;
	logic rd_en;
	logic [RAW-1:0] rd_addr;
	logic wr_en;
	logic res_push;
	logic res_status;
	logic [7:0] res_data;
	logic dirty_en;
	logic dirty_new;
	logic fill_en;

	assign res_free = !res_vld_q || !out_stall;
	assign last_row = (nxt_row_q == cur_q.y1);
	// Rows never written since the last fill read as the fill value.
	assign eff_row = rd_vld_q ? rd_data_q : {W{fill_val_q}};
	assign merged = cur_q.set ? (eff_row | mask_q) : (eff_row & ~mask_q);
	assign byte_idx = cur_q.x0[3 +: BW];
	assign sel_byte = eff_row[{byte_idx, 3'b000} +: 8];

	always_comb begin
		logic [XW-1:0] px;
		for (int i = 0; i < W; i++) begin
			px = XW'(((i >> 3) << 3) + 7 - (i & 7));
			mask_d[i] = (px >= head.x0) && (px < head.x1);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_status.empty) begin
					if (head.kind == K_RMW) begin
						state_d = B_RMW;
					end else if (head.kind == K_READ) begin
						state_d = B_READ;
					end
				end
			end
			B_RMW: begin
				if (last_row && res_free) begin
					state_d = B_IDLE;
				end
			end
			B_READ: begin
				if (res_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		ld_cur = 1'b0;
		rd_en = 1'b0;
		rd_addr = head.y0[RAW-1:0];
		wr_en = 1'b0;
		res_push = 1'b0;
		res_status = 1'b0;
		res_data = 8'h00;
		dirty_en = 1'b0;
		dirty_new = 1'b0;
		fill_en = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_status.empty) begin
					unique case (head.kind)
						K_RMW, K_READ: begin
							pop = 1'b1;
							ld_cur = 1'b1;
							rd_en = 1'b1;
						end
						K_FILL: begin
							if (res_free) begin
								pop = 1'b1;
								res_push = 1'b1;
								fill_en = 1'b1;
								dirty_en = 1'b1;
								dirty_new = 1'b1;
							end
						end
						K_FLUSH: begin
							if (res_free) begin
								pop = 1'b1;
								res_push = 1'b1;
								dirty_en = 1'b1;
								dirty_new = 1'b0;
							end
						end
						default: begin
							if (res_free) begin
								pop = 1'b1;
								res_push = 1'b1;
								res_status = head.status;
							end
						end
					endcase
				end
			end
			B_RMW: begin
				if (!last_row) begin
					// Write this row back while the next one is read.
					wr_en = 1'b1;
					rd_en = 1'b1;
					rd_addr = nxt_row_q[RAW-1:0];
				end else if (res_free) begin
					wr_en = 1'b1;
					res_push = 1'b1;
					dirty_en = cur_q.mark;
					dirty_new = 1'b1;
				end
			end
			B_READ: begin
				if (res_free) begin
					res_push = 1'b1;
					res_data = sel_byte;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			row_vld_q <= '0;
			fill_val_q <= 1'b0;
			dirty_q <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fill_en) begin
				row_vld_q <= '0;
				fill_val_q <= head.set;
			end else if (wr_en) begin
				row_vld_q[wr_row_q] <= 1'b1;
			end
			if (dirty_en) begin
				dirty_q <= dirty_new;
			end
			if (res_push) begin
				res_vld_q <= 1'b1;
			end else if (!out_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_cur) begin
			cur_q <= head;
			mask_q <= mask_d;
			wr_row_q <= head.y0[RAW-1:0];
			nxt_row_q <= head.y0 + YW'(1);
		end else if (state_q == B_RMW && !last_row) begin
			wr_row_q <= nxt_row_q[RAW-1:0];
			nxt_row_q <= nxt_row_q + YW'(1);
		end
		if (res_push) begin
			res_status_q <= res_status;
			res_data_q <= res_data;
			res_dirty_q <= dirty_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_row_q] <= merged;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			rd_vld_q <= row_vld_q[rd_addr];
		end
	end

	assign out_valid = res_vld_q;
	assign status = res_status_q;
	assign read_data = res_data_q;
	assign dirty_flag = res_dirty_q;

endmodule

// ===== bench/tb_mono_framebuffer_draw_engine_top.sv =====
// Self-checking testbench for mono_framebuffer_draw_engine_top.
// It keeps its own copy of the 1-bit-per-pixel frame store in a small class and
// checks every reply. Depends on mfde_pkg and the draw engine RTL only.
module tb_mono_framebuffer_draw_engine_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mfde_pkg::*;

	localparam int ROW_BYTES = 16;
	localparam int ROWS = 36;
	localparam int SCREEN_W = ROW_BYTES * 8;
	localparam int RANDOM_COMMANDS = 1170;
	// Opcodes 6 and 7 have no meaning. The engine must reject them and
	// leave the store alone.
	localparam logic [2:0] OP_RESERVED_LO = 3'd6;
	localparam logic [2:0] OP_RESERVED_HI = 3'd7;

	// The class below mirrors the frame store and the dirty flag. Every command
	// transfer is applied to the mirror at once, and the reply that the command
	// must produce is queued. Replies leave the engine in command order, so
	// each one is checked against the oldest entry in the queue.
	class frame_shadow;
		typedef struct {
			logic status;
			logic [7:0] read_data;
			logic dirty_flag;
		} reply_t;

		logic [7:0] store [ROW_BYTES*ROWS];
		logic dirty;
		reply_t replies [$];
		int failures;

		function new();
			foreach (store[i]) store[i] = 8'h00;
			dirty = 1'b0;
			failures = 0;
		endfunction

		function int pending();
			return replies.size();
		endfunction

		function void apply_command(logic [2:0] c_op, logic [7:0] xs, logic [5:0] ys,
				logic [7:0] xe, logic [5:0] ye, logic pv);
			reply_t r;
			int idx;
			int row;
			int col;
			logic [7:0] mask;
			r.status = 1'b0;
			r.read_data = 8'h00;
			r.dirty_flag = dirty;
			case (c_op)
				OP_SET_PIXEL: begin
					if (xs >= SCREEN_W || ys >= ROWS) begin
						r.status = 1'b1;
					end else begin
						idx = ys * ROW_BYTES + xs[7:3];
						mask = 8'h80 >> xs[2:0];
						store[idx] = pv ? (store[idx] | mask) : (store[idx] & ~mask);
					end
				end
				OP_FILL_SCREEN: begin
					foreach (store[i]) store[i] = pv ? 8'hFF : 8'h00;
					dirty = 1'b1;
				end
				OP_CLEAR_RECT, OP_FILL_RECT: begin
					// Exclusive edges may equal the screen size. Anything past
					// it, or an empty span, rejects the whole rectangle.
					if (xs > SCREEN_W || xe > SCREEN_W || ys > ROWS || ye > ROWS ||
							xs >= xe || ys >= ye) begin
						r.status = 1'b1;
					end else begin
						for (row = ys; row < ye; row++) begin
							for (col = xs; col < xe; col++) begin
								idx = row * ROW_BYTES + col / 8;
								mask = 8'h80 >> (col % 8);
								if (c_op == OP_FILL_RECT)
									store[idx] = store[idx] | mask;
								else
									store[idx] = store[idx] & ~mask;
							end
						end
						dirty = 1'b1;
					end
				end
				OP_READ_BYTE: begin
					if (ys >= ROWS || xs[7:3] >= ROW_BYTES)
						r.status = 1'b1;
					else
						r.read_data = store[ys * ROW_BYTES + xs[7:3]];
				end
				OP_FLUSH: dirty = 1'b0;
				default: r.status = 1'b1;
			endcase
			replies.push_back(r);
		endfunction

		function void check_reply(logic st, logic [7:0] rd, logic df);
			reply_t r;
			if (replies.size() == 0) begin
				$error("reply transfer with no command waiting for it");
				failures++;
				return;
			end
			r = replies.pop_front();
			if (st !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, st);
				failures++;
			end
			if (rd !== r.read_data) begin
				$error("read_data: expected 0x%02h, got 0x%02h", r.read_data, rd);
				failures++;
			end
			if (df !== r.dirty_flag) begin
				$error("dirty_flag: expected %0d, got %0d", r.dirty_flag, df);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] op;
	logic [7:0] x_start;
	logic [5:0] y_start;
	logic [7:0] x_end;
	logic [5:0] y_end;
	logic pixel_value;
	logic out_valid;
	logic out_stall;
	logic status;
	logic [7:0] read_data;
	logic dirty_flag;

	frame_shadow shadow;

	// Calm stretches turn off all idling on one side. The hold request asks
	// the reply side for one long stall while commands keep coming.
	bit calm_send;
	bit calm_reply;
	bit hold_request;
	bit hold_done;

	mono_framebuffer_draw_engine_top #(
		.ROW_BYTES(ROW_BYTES),
		.ROWS(ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.pixel_value(pixel_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.read_data(read_data),
		.dirty_flag(dirty_flag)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Pause length in cycles. Most pauses are zero or short, and a few are long
	// enough to let a full-height rectangle finish while one side waits.
	function automatic int pick_pause(bit calm);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one command and holds it until the engine takes it. The mirror is
	// updated at the edge of the transfer. Valid drops only for a real gap, so
	// back-to-back commands keep it high without a glitch.
	task automatic send_command(logic [2:0] c_op, logic [7:0] xs, logic [5:0] ys,
			logic [7:0] xe, logic [5:0] ye, logic pv);
		int gap;
		in_valid <= 1'b1;
		op <= c_op;
		x_start <= xs;
		y_start <= ys;
		x_end <= xe;
		y_end <= ye;
		pixel_value <= pv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		shadow.apply_command(c_op, xs, ys, xe, ye, pv);
		if ($urandom_range(0, 39) == 0 && !hold_request)
			calm_send = !calm_send;
		gap = pick_pause(calm_send);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// One random command. Most are well formed with random content; about a
	// quarter are raw noise over every field, which covers the rejected cases,
	// the unused opcodes and every bit of every field.
	task automatic send_random_command();
		int roll;
		logic [2:0] c_op;
		logic [7:0] xs;
		logic [7:0] xe;
		logic [5:0] ys;
		logic [5:0] ye;
		logic pv;
		roll = $urandom_range(0, 99);
		c_op = 3'($urandom_range(0, 7));
		xs = 8'($urandom_range(0, 255));
		xe = 8'($urandom_range(0, 255));
		ys = 6'($urandom_range(0, 63));
		ye = 6'($urandom_range(0, 63));
		pv = 1'($urandom_range(0, 1));
		if (roll < 22) begin
			c_op = OP_SET_PIXEL;
			xs = 8'($urandom_range(0, SCREEN_W - 1));
			ys = 6'($urandom_range(0, ROWS - 1));
		end else if (roll < 40) begin
			c_op = OP_READ_BYTE;
			xs = 8'($urandom_range(0, SCREEN_W - 1));
			ys = 6'($urandom_range(0, ROWS - 1));
		end else if (roll < 62) begin
			c_op = $urandom_range(0, 1) ? OP_FILL_RECT : OP_CLEAR_RECT;
			xs = 8'($urandom_range(0, SCREEN_W - 1));
			ys = 6'($urandom_range(0, ROWS - 1));
			// Mostly small rectangles so that partial bytes stay common and
			// the run stays short; now and then one runs to the far edges.
			if ($urandom_range(0, 3) != 0) begin
				xe = 8'($urandom_range(xs + 1, (xs + 20 > SCREEN_W) ? SCREEN_W : xs + 20));
				ye = 6'($urandom_range(ys + 1, (ys + 6 > ROWS) ? ROWS : ys + 6));
			end else begin
				xe = 8'($urandom_range(xs + 1, SCREEN_W));
				ye = 6'($urandom_range(ys + 1, ROWS));
			end
		end else if (roll < 66) begin
			c_op = OP_FILL_SCREEN;
		end else if (roll < 76) begin
			c_op = OP_FLUSH;
		end
		send_command(c_op, xs, ys, xe, ye, pv);
	endtask

	// Reply side: the monitor checks every reply transfer, using the values
	// that stood before the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.check_reply(status, read_data, dirty_flag);
	end

	// Reply side: stall driver. Stalls and open runs alternate, with calm
	// stretches that never stall, and one long hold when the command side asks.
	initial begin
		int stall_len;
		int hold_cycles;
		out_stall = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request && !hold_done) begin
				out_stall <= 1'b1;
				hold_cycles = 0;
				while (hold_cycles < 300) begin
					@(posedge clk);
					hold_cycles++;
				end
				hold_done = 1'b1;
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				if ($urandom_range(0, 29) == 0)
					calm_reply = !calm_reply;
				stall_len = pick_pause(calm_reply);
				if (stall_len > 0) begin
					out_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat (calm_reply ? 20 : $urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	// Command side: reset, the directed commands, then the random ones, then
	// the drain and the verdict.
	initial begin
		shadow = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_SET_PIXEL;
		x_start = 8'h00;
		y_start = 6'h00;
		x_end = 8'h00;
		y_end = 6'h00;
		pixel_value = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// The store must read as zeros straight out of reset.
		send_command(OP_READ_BYTE, 8'd0, 6'd0, 8'd0, 6'd0, 1'b0);
		// Corner pixels, then pixels just past each edge and at the top of
		// the field ranges, which must be ignored.
		send_command(OP_SET_PIXEL, 8'd0, 6'd0, 8'd255, 6'd63, 1'b1);
		send_command(OP_SET_PIXEL, 8'd127, 6'd35, 8'd0, 6'd0, 1'b1);
		send_command(OP_SET_PIXEL, 8'd128, 6'd0, 8'd0, 6'd0, 1'b1);
		send_command(OP_SET_PIXEL, 8'd0, 6'd36, 8'd0, 6'd0, 1'b1);
		send_command(OP_SET_PIXEL, 8'd255, 6'd63, 8'd0, 6'd0, 1'b1);
		// The leftmost pixel is the MSB, the rightmost the LSB.
		send_command(OP_READ_BYTE, 8'd0, 6'd0, 8'd0, 6'd0, 1'b0);
		send_command(OP_READ_BYTE, 8'd127, 6'd35, 8'd0, 6'd0, 1'b0);
		// Reads past the screen are rejected and return zero.
		send_command(OP_READ_BYTE, 8'd128, 6'd0, 8'd0, 6'd0, 1'b0);
		send_command(OP_READ_BYTE, 8'd0, 6'd36, 8'd0, 6'd0, 1'b0);
		send_command(OP_READ_BYTE, 8'd255, 6'd63, 8'd255, 6'd63, 1'b1);
		// Pixel writes leave the store clean.
		send_command(OP_FLUSH, 8'd0, 6'd0, 8'd0, 6'd0, 1'b0);
		// A rectangle that starts and ends inside bytes.
		send_command(OP_FILL_RECT, 8'd3, 6'd2, 8'd13, 6'd5, 1'b0);
		send_command(OP_READ_BYTE, 8'd8, 6'd3, 8'd0, 6'd0, 1'b0);
		send_command(OP_READ_BYTE, 8'd0, 6'd2, 8'd0, 6'd0, 1'b0);
		// A rectangle that covers the whole screen, exclusive edges at the limit.
		send_command(OP_CLEAR_RECT, 8'd0, 6'd0, 8'd128, 6'd36, 1'b0);
		// Edges past the screen, and empty or inverted spans, are rejected.
		send_command(OP_FILL_RECT, 8'd0, 6'd0, 8'd129, 6'd36, 1'b0);
		send_command(OP_FILL_RECT, 8'd0, 6'd0, 8'd128, 6'd37, 1'b0);
		send_command(OP_CLEAR_RECT, 8'd5, 6'd1, 8'd5, 6'd4, 1'b0);
		send_command(OP_CLEAR_RECT, 8'd5, 6'd4, 8'd9, 6'd3, 1'b0);
		send_command(OP_FILL_RECT, 8'd255, 6'd63, 8'd255, 6'd63, 1'b1);
		// Flush reports the flag once and clears it.
		send_command(OP_FLUSH, 8'd0, 6'd0, 8'd0, 6'd0, 1'b0);
		send_command(OP_FLUSH, 8'd0, 6'd0, 8'd0, 6'd0, 1'b0);
		// Fill the screen, punch one pixel out of it, then clear it again.
		send_command(OP_FILL_SCREEN, 8'd0, 6'd0, 8'd0, 6'd0, 1'b1);
		send_command(OP_SET_PIXEL, 8'd9, 6'd1, 8'd0, 6'd0, 1'b0);
		send_command(OP_READ_BYTE, 8'd8, 6'd1, 8'd0, 6'd0, 1'b0);
		send_command(OP_FILL_SCREEN, 8'd255, 6'd63, 8'd255, 6'd63, 1'b0);
		// Unused opcodes change nothing.
		send_command(OP_RESERVED_LO, 8'd4, 6'd4, 8'd60, 6'd20, 1'b1);
		send_command(OP_RESERVED_HI, 8'd4, 6'd4, 8'd60, 6'd20, 1'b1);

		// At the start of the random part the reply side holds off for a long
		// stretch while commands keep coming with no gaps, so the queue fills
		// and the engine must stall its input.
		hold_request = 1'b1;
		calm_send = 1'b1;
		for (int n = 0; n < RANDOM_COMMANDS; n++) begin
			if (n == 60)
				calm_send = 1'b0;
			send_random_command();
		end
		in_valid <= 1'b0;

		while (shadow.pending() != 0) @(posedge clk);
		// Room for a stray reply to show up after the last expected one.
		repeat (100) @(posedge clk);
		if (shadow.failures == 0 && shadow.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, in which every command
	// meets the longest gap, the longest stall and a full-height rectangle.
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
